FILE: hdl/mnas_pkg.sv
// Shared constants, types and the stamp step table of the MNA stamping block.
`timescale 1ns / 1ps

package mnas_pkg;

   localparam int MAX_UNKNOWNS_DEF = 64;
   localparam int FRAC_BITS_DEF    = 16;

   // Request types.
   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_STAMP = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // Component kinds.
   localparam logic [2:0] KIND_R    = 3'd0;
   localparam logic [2:0] KIND_G    = 3'd1;
   localparam logic [2:0] KIND_ISRC = 3'd2;
   localparam logic [2:0] KIND_VSRC = 3'd3;
   localparam logic [2:0] KIND_VCCS = 3'd4;
   localparam logic [2:0] KIND_VCVS = 3'd5;
   localparam logic [2:0] KIND_CCVS = 3'd6;
   localparam logic [2:0] KIND_CCCS = 3'd7;

   // Node selectors of one step.
   localparam logic [2:0] SEL_P  = 3'd0;
   localparam logic [2:0] SEL_N  = 3'd1;
   localparam logic [2:0] SEL_CP = 3'd2;
   localparam logic [2:0] SEL_CN = 3'd3;
   localparam logic [2:0] SEL_K1 = 3'd4;
   localparam logic [2:0] SEL_K2 = 3'd5;

   // Increment selectors of one step.
   localparam logic [2:0] D_G     = 3'd0;
   localparam logic [2:0] D_NG    = 3'd1;
   localparam logic [2:0] D_ONE   = 3'd2;
   localparam logic [2:0] D_NONE  = 3'd3;
   localparam logic [2:0] D_GAIN  = 3'd4;
   localparam logic [2:0] D_NGAIN = 3'd5;
   localparam logic [2:0] D_VAL   = 3'd6;
   localparam logic [2:0] D_NVAL  = 3'd7;

   typedef struct packed {
      logic       valid;
      logic       is_rhs;
      logic [2:0] row_sel;
      logic [2:0] col_sel;
      logic [2:0] dsel;
   } op_type;

   function automatic op_type op_make(logic is_rhs, logic [2:0] r, logic [2:0] c,
                                      logic [2:0] d);
      op_type o;
      o.valid   = 1'b1;
      o.is_rhs  = is_rhs;
      o.row_sel = r;
      o.col_sel = c;
      o.dsel    = d;
      return o;
   endfunction

   // One read-modify-write step of a stamp; an invalid step ends the stamp.
   function automatic op_type op_lookup(logic [2:0] kind, logic [3:0] step);
      op_type o;
      o = '0;
      case (kind) inside
         KIND_R, KIND_G: begin
            case (step)
               4'd0: o = op_make(1'b0, SEL_P, SEL_P, D_G);
               4'd1: o = op_make(1'b0, SEL_P, SEL_N, D_NG);
               4'd2: o = op_make(1'b0, SEL_N, SEL_P, D_NG);
               4'd3: o = op_make(1'b0, SEL_N, SEL_N, D_G);
               default: o = '0;
            endcase
         end
         KIND_ISRC: begin
            case (step)
               4'd0: o = op_make(1'b1, SEL_P, SEL_P, D_NVAL);
               4'd1: o = op_make(1'b1, SEL_N, SEL_N, D_VAL);
               default: o = '0;
            endcase
         end
         KIND_VSRC: begin
            case (step)
               4'd0: o = op_make(1'b1, SEL_K1, SEL_K1, D_VAL);
               4'd1: o = op_make(1'b0, SEL_P, SEL_K1, D_ONE);
               4'd2: o = op_make(1'b0, SEL_N, SEL_K1, D_NONE);
               4'd3: o = op_make(1'b0, SEL_K1, SEL_P, D_ONE);
               4'd4: o = op_make(1'b0, SEL_K1, SEL_N, D_NONE);
               default: o = '0;
            endcase
         end
         KIND_VCCS: begin
            case (step)
               4'd0: o = op_make(1'b0, SEL_P, SEL_K1, D_GAIN);
               4'd1: o = op_make(1'b0, SEL_N, SEL_K1, D_NGAIN);
               4'd2: o = op_make(1'b0, SEL_K1, SEL_K1, D_NONE);
               4'd3: o = op_make(1'b0, SEL_K1, SEL_CP, D_ONE);
               4'd4: o = op_make(1'b0, SEL_K1, SEL_CN, D_NONE);
               default: o = '0;
            endcase
         end
         KIND_VCVS, KIND_CCVS: begin
            case (step)
               4'd0: o = op_make(1'b0, SEL_P, SEL_K1, D_ONE);
               4'd1: o = op_make(1'b0, SEL_N, SEL_K1, D_NONE);
               4'd2: o = op_make(1'b0, SEL_K1, SEL_P, D_ONE);
               4'd3: o = op_make(1'b0, SEL_K1, SEL_N, D_NONE);
               4'd4: o = op_make(1'b0, SEL_K1, SEL_K2, D_NGAIN);
               4'd5: o = op_make(1'b0, SEL_K2, SEL_CP, D_ONE);
               4'd6: o = op_make(1'b0, SEL_K2, SEL_CN, D_NONE);
               4'd7: begin
                  if (kind == KIND_VCVS) o = op_make(1'b0, SEL_K2, SEL_K2, D_NONE);
                  else o = op_make(1'b0, SEL_CP, SEL_K2, D_ONE);
               end
               4'd8: begin
                  if (kind == KIND_CCVS) o = op_make(1'b0, SEL_CN, SEL_K2, D_NONE);
                  else o = '0;
               end
               default: o = '0;
            endcase
         end
         default: begin
            case (step)
               4'd0: o = op_make(1'b0, SEL_P, SEL_K1, D_GAIN);
               4'd1: o = op_make(1'b0, SEL_N, SEL_K1, D_NGAIN);
               4'd2: o = op_make(1'b0, SEL_K1, SEL_CP, D_ONE);
               4'd3: o = op_make(1'b0, SEL_K1, SEL_CN, D_NONE);
               4'd4: o = op_make(1'b0, SEL_CP, SEL_K1, D_ONE);
               4'd5: o = op_make(1'b0, SEL_CN, SEL_K1, D_NONE);
               default: o = '0;
            endcase
         end
      endcase
      return o;
   endfunction

endpackage

FILE: hdl/mna_matrix_stamping_top.sv
// Top level of the MNA stamping block: sequencer, divider, matrix and rhs memories.
`timescale 1ns / 1ps
// A read passes through the memory read and capture states to its result; a stamp
// reads and writes each stored entry and skips each grounded step (at most 9
// steps), after a bit-serial reciprocal for a resistor. A clear zeroes the whole
// matrix and rhs store. One request is in work at a time and the next is taken
// only once the result has been transferred. After reset a clearing pass over the
// whole store runs before the first request is taken.

module mna_matrix_stamping_top #(
   parameter int FRAC_BITS    = mnas_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [6:0]         csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [2:0]         req_comp_kind,
   input  logic [6:0]         req_node_pos,
   input  logic [6:0]         req_node_neg,
   input  logic [6:0]         req_ctrl_pos,
   input  logic [6:0]         req_ctrl_neg,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_gain,
   input  logic [5:0]         req_read_row,
   input  logic [5:0]         req_read_col,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_matrix_value,
   output logic signed [31:0] rsp_rhs_value,
   output logic [6:0]         rsp_unknown_total,
   output logic               rsp_error_flag
);

   // The store size is fixed by the 6-bit read and 7-bit node fields.
   localparam int MAX_UNKNOWNS = mnas_pkg::MAX_UNKNOWNS_DEF;

   // Widths that follow from the store size and the fixed-point format.
   localparam int UW  = $clog2(MAX_UNKNOWNS + 1);
   localparam int NW  = (UW > 7) ? UW : 7;
   localparam int AW  = $clog2(MAX_UNKNOWNS * MAX_UNKNOWNS);
   localparam int RW  = $clog2(MAX_UNKNOWNS);
   localparam int QW  = 2 * FRAC_BITS + 1;
   localparam int CW  = $clog2(QW);
   localparam int SQW = (QW + 1 > 34) ? QW + 1 : 34;
   localparam int TINY_LIMIT = ((1 << FRAC_BITS) - 1) / 1000000;
   localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

   // Sequencer state codes.
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CLEAR  = 4'd1;
   localparam logic [3:0] ST_CHECK  = 4'd2;
   localparam logic [3:0] ST_DIV    = 4'd3;
   localparam logic [3:0] ST_DIVFIN = 4'd4;
   localparam logic [3:0] ST_OPRD   = 4'd5;
   localparam logic [3:0] ST_OPWR   = 4'd6;
   localparam logic [3:0] ST_RDMEM  = 4'd7;
   localparam logic [3:0] ST_RDCAP  = 4'd8;
   localparam logic [3:0] ST_RESP   = 4'd9;

   logic [3:0]         state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               clr_resp_ff, clr_resp_in;
   logic [6:0]         ncount_ff, ncount_in;
   logic [UW-1:0]      uc_ff, uc_in;
   logic [3:0]         step_ff, step_in;
   logic [CW-1:0]      bit_ff, bit_in;
   logic [31:0]        rem_ff, rem_in;
   logic [QW-1:0]      quo_ff, quo_in;
   logic signed [31:0] cond_ff, cond_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               err_ff, err_in;
   logic signed [31:0] resm_ff, resm_in;
   logic signed [31:0] resr_ff, resr_in;

   // Latched request fields.
   logic [1:0]         type_ff;
   logic [2:0]         kind_ff;
   logic [NW-1:0]      np_ff, nn_ff, cp_ff, cn_ff, k1_ff, k2_ff;
   logic [NW-1:0]      k1_in, k2_in;
   logic signed [31:0] val_ff, gain_ff;
   logic [5:0]         rrow_ff, rcol_ff;

   // Memories and their registered read data.
   logic signed [31:0] mat_mem [MAX_UNKNOWNS * MAX_UNKNOWNS];
   logic signed [31:0] rhs_mem [MAX_UNKNOWNS];
   logic signed [31:0] mrd_ff, rrd_ff;
   logic [AW-1:0]      maddr;
   logic [RW-1:0]      raddr;
   logic               mwe, rwe;
   logic signed [31:0] wdata;

   mnas_pkg::op_type   op;
   logic [NW-1:0]      op_row, op_col;
   logic               op_skip;
   logic signed [33:0] delta, old34, sum;
   logic signed [31:0] sum_sat;
   logic               sum_ovf;
   logic [31:0]        vmag;
   logic               node_bad, ctrl_bad, tiny, full;
   logic [1:0]         need;
   logic [32:0]        rshift;
   logic               rge;
   logic signed [SQW-1:0] qs;
   logic               q_ovf;
   logic               read_ok;
   logic               accept;

   assign accept    = req_valid && !req_stall;
   // A new request waits until the previous result has been taken, so the
   // result payload stays put while it is stalled.
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;

   // Step decode and node selection.
   assign op = mnas_pkg::op_lookup(kind_ff, step_ff);

   function automatic logic [NW-1:0] sel_node(logic [2:0] s, logic [NW-1:0] p,
      logic [NW-1:0] n, logic [NW-1:0] cp, logic [NW-1:0] cn, logic [NW-1:0] k1,
      logic [NW-1:0] k2);
      logic [NW-1:0] r;
      unique case (s)
         mnas_pkg::SEL_P:  r = p;
         mnas_pkg::SEL_N:  r = n;
         mnas_pkg::SEL_CP: r = cp;
         mnas_pkg::SEL_CN: r = cn;
         mnas_pkg::SEL_K1: r = k1;
         default:          r = k2;
      endcase
      return r;
   endfunction

   assign op_row  = sel_node(op.row_sel, np_ff, nn_ff, cp_ff, cn_ff, k1_ff, k2_ff);
   assign op_col  = sel_node(op.col_sel, np_ff, nn_ff, cp_ff, cn_ff, k1_ff, k2_ff);
   // Ground rows and columns are not stored.
   assign op_skip = (op_row == '0) || (!op.is_rhs && (op_col == '0));

   always_comb begin
      case (op.dsel)
         mnas_pkg::D_G:     delta = 34'(cond_ff);
         mnas_pkg::D_NG:    delta = -34'(cond_ff);
         mnas_pkg::D_ONE:   delta = ONE;
         mnas_pkg::D_NONE:  delta = -ONE;
         mnas_pkg::D_GAIN:  delta = 34'(gain_ff);
         mnas_pkg::D_NGAIN: delta = -34'(gain_ff);
         mnas_pkg::D_VAL:   delta = 34'(val_ff);
         default:           delta = -34'(val_ff);
      endcase
   end

   // Saturating accumulate: the sum fits 32 bits when its top three bits agree.
   assign old34   = op.is_rhs ? 34'(rrd_ff) : 34'(mrd_ff);
   assign sum     = old34 + delta;
   assign sum_ovf = !((sum[33:31] == 3'b000) || (sum[33:31] == 3'b111));
   assign sum_sat = !sum_ovf ? sum[31:0] : (sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

   // Stamp screening on the latched request.
   assign vmag     = val_ff[31] ? 32'(-val_ff) : 32'(val_ff);
   assign node_bad = (np_ff > NW'(uc_ff)) || (nn_ff > NW'(uc_ff));
   assign ctrl_bad = kind_ff[2] && ((cp_ff > NW'(uc_ff)) || (cn_ff > NW'(uc_ff)));
   assign tiny     = (kind_ff == mnas_pkg::KIND_VSRC) && (vmag <= 32'(TINY_LIMIT));
   always_comb begin
      case (kind_ff) inside
         mnas_pkg::KIND_VSRC, mnas_pkg::KIND_VCCS, mnas_pkg::KIND_CCCS: need = 2'd1;
         mnas_pkg::KIND_VCVS, mnas_pkg::KIND_CCVS:                      need = 2'd2;
         default:                                                       need = 2'd0;
      endcase
   end
   assign full  = (32'(uc_ff) + 32'(need)) > MAX_UNKNOWNS;
   assign k1_in = NW'(uc_ff) + NW'(1);
   assign k2_in = NW'(uc_ff) + NW'(2);

   // Restoring divider step for 2^(2*FRAC_BITS) / |value|.
   assign rshift = {rem_ff, (32'(bit_ff) == 2 * FRAC_BITS)};
   assign rge    = rshift >= {1'b0, vmag};
   assign qs     = val_ff[31] ? -$signed(SQW'(quo_ff)) : $signed(SQW'(quo_ff));
   assign q_ovf  = !((qs[SQW-1:31] == '0) || (qs[SQW-1:31] == '1));

   assign read_ok = (32'(rrow_ff) < MAX_UNKNOWNS) && (32'(rcol_ff) < MAX_UNKNOWNS);

   // Memory port selection.
   always_comb begin
      maddr = AW'((32'(op_row) - 32'd1) * MAX_UNKNOWNS + (32'(op_col) - 32'd1));
      raddr = RW'(32'(op_row) - 32'd1);
      mwe   = 1'b0;
      rwe   = 1'b0;
      wdata = sum_sat;
      if (state_ff == ST_CLEAR) begin
         maddr = clr_ff;
         raddr = RW'(clr_ff);
         mwe   = 1'b1;
         rwe   = (32'(clr_ff) < MAX_UNKNOWNS);
         wdata = '0;
      end else if (state_ff == ST_RDMEM) begin
         maddr = AW'(32'(rrow_ff) * MAX_UNKNOWNS + 32'(rcol_ff));
         raddr = RW'(rrow_ff);
      end else if (state_ff == ST_OPWR) begin
         mwe = !op.is_rhs;
         rwe = op.is_rhs;
      end
   end

   always_ff @(posedge clock) begin
      if (mwe) begin
         mat_mem[maddr] <= wdata;
      end
      mrd_ff <= mat_mem[maddr];
   end

   always_ff @(posedge clock) begin
      if (rwe) begin
         rhs_mem[raddr] <= wdata;
      end
      rrd_ff <= rhs_mem[raddr];
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      clr_resp_in  = clr_resp_ff;
      ncount_in    = csr_wr_en ? csr_wr_data : ncount_ff;
      uc_in        = uc_ff;
      step_in      = step_ff;
      bit_in       = bit_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cond_in      = cond_ff;
      err_in       = err_ff;
      resm_in      = resm_ff;
      resr_in      = resr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               err_in  = 1'b0;
               resm_in = '0;
               resr_in = '0;
               case (req_type)
                  mnas_pkg::REQ_CLEAR: begin
                     state_in    = ST_CLEAR;
                     clr_in      = '0;
                     clr_resp_in = 1'b1;
                     uc_in       = (32'(ncount_ff) > MAX_UNKNOWNS) ?
                                   UW'(MAX_UNKNOWNS) : UW'(ncount_ff);
                  end
                  mnas_pkg::REQ_STAMP: state_in = ST_CHECK;
                  mnas_pkg::REQ_READ:  state_in = ST_RDMEM;
                  default:             state_in = ST_RESP;
               endcase
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_UNKNOWNS * MAX_UNKNOWNS - 1)) begin
               state_in = clr_resp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_CHECK: begin
            step_in = '0;
            cond_in = val_ff;
            if (node_bad || ctrl_bad) begin
               err_in   = 1'b1;
               state_in = ST_RESP;
            end else if (tiny) begin
               state_in = ST_RESP;
            end else if (full || ((kind_ff == mnas_pkg::KIND_R) && (val_ff == '0))) begin
               err_in   = 1'b1;
               state_in = ST_RESP;
            end else begin
               uc_in = uc_ff + UW'(need);
               if (kind_ff == mnas_pkg::KIND_R) begin
                  bit_in   = CW'(QW - 1);
                  rem_in   = '0;
                  quo_in   = '0;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_OPRD;
               end
            end
         end
         ST_DIV: begin
            rem_in = rge ? 32'(rshift - {1'b0, vmag}) : rshift[31:0];
            quo_in = {quo_ff[QW-2:0], rge};
            bit_in = bit_ff - CW'(1);
            if (bit_ff == '0) begin
               state_in = ST_DIVFIN;
            end
         end
         ST_DIVFIN: begin
            if (q_ovf) begin
               err_in  = 1'b1;
               cond_in = qs[SQW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
               cond_in = qs[31:0];
            end
            state_in = ST_OPRD;
         end
         ST_OPRD: begin
            if (!op.valid) begin
               state_in = ST_RESP;
            end else if (op_skip) begin
               step_in = step_ff + 4'd1;
            end else begin
               state_in = ST_OPWR;
            end
         end
         ST_OPWR: begin
            if (sum_ovf) begin
               err_in = 1'b1;
            end
            step_in  = step_ff + 4'd1;
            state_in = ST_OPRD;
         end
         ST_RDMEM: begin
            if (read_ok) begin
               state_in = ST_RDCAP;
            end else begin
               err_in   = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RDCAP: begin
            resm_in  = mrd_ff;
            resr_in  = rrd_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // Hold until the previous result has been taken.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         clr_resp_ff  <= 1'b0;
         ncount_ff    <= 7'd1;
         uc_ff        <= UW'(1);
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         bit_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_resp_ff  <= clr_resp_in;
         ncount_ff    <= ncount_in;
         uc_ff        <= uc_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         bit_ff       <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cond_ff <= cond_in;
      err_ff  <= err_in;
      resm_ff <= resm_in;
      resr_ff <= resr_in;
      if (state_ff == ST_CHECK) begin
         k1_ff <= k1_in;
         k2_ff <= k2_in;
      end
      if (accept) begin
         type_ff <= req_type;
         kind_ff <= req_comp_kind;
         np_ff   <= NW'(req_node_pos);
         nn_ff   <= NW'(req_node_neg);
         cp_ff   <= NW'(req_ctrl_pos);
         cn_ff   <= NW'(req_ctrl_neg);
         val_ff  <= req_value;
         gain_ff <= req_gain;
         rrow_ff <= req_read_row;
         rcol_ff <= req_read_col;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matrix_value  = resm_ff;
   assign rsp_rhs_value     = resr_ff;
   assign rsp_unknown_total = 7'(uc_ff);
   assign rsp_error_flag    = err_ff;

   // A result appears only out of the response state.
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP)
      else $error("result raised outside the response state");

   // The unknown count never passes the store size.
   a_uc_bound: assert property (@(posedge clock) disable iff (reset)
      32'(uc_ff) <= MAX_UNKNOWNS)
      else $error("unknown count beyond store size");

   // The matrix memory is written only by the clearing pass or a stamp step.
   a_mwe_state: assert property (@(posedge clock) disable iff (reset)
      mwe |-> (state_ff == ST_OPWR || state_ff == ST_CLEAR))
      else $error("matrix write outside a write state");

   // A stamp only reaches its steps for a stamp request.
   a_step_type: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OPWR) |-> (type_ff == mnas_pkg::REQ_STAMP))
      else $error("stamp step for a non-stamp request");

endmodule
